[src/assert_macros.svh]
// Assertion macros shared by the buffer controller modules.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HDUB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HDUB_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HDUB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDUB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[src/hdub_pkg.sv]
// Types, codes and helper functions of the half-duplex UART buffer controller.
// No dependencies; used by every module of the block.
package hdub_pkg;

  localparam int unsigned InBytes  = 1;
  localparam int unsigned OutWidth = 24;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_SHIFT = 2'd3
  } hdub_op_e;

  typedef enum logic [1:0] {
    LD_NONE   = 2'd0,
    LD_START  = 2'd1,
    LD_FIRST  = 2'd2,
    LD_SECOND = 2'd3
  } hdub_load_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_FINISH = 2'b10
  } hdub_state_e;

  localparam logic [7:0] StartLoad  = 8'hFF;
  localparam logic [7:0] FirstMark  = 8'h80;
  localparam logic [7:0] SecondMark = 8'h07;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;    // an item is transferred in this cycle
    logic finish;  // move the result into the output register
  } hdub_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register is empty or being drained
  } hdub_status_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] x;
    x = ((v >> 1) & 8'h55) | ((v << 1) & 8'haa);
    x = ((x >> 2) & 8'h33) | ((x << 2) & 8'hcc);
    x = ((x >> 4) & 8'h0f) | ((x << 4) & 8'hf0);
    return x;
  endfunction

endpackage

[src/hdub_ctrl.sv]
// Controller state machine of the half-duplex UART buffer controller.
// Depends on hdub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hdub_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hdub_pkg::hdub_status_t status_i,
  output hdub_pkg::hdub_cmd_t    cmd_o
);

  hdub_pkg::hdub_state_e state_q, state_d;

  assign in_ready_o = (state_q == hdub_pkg::ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.exec    = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      hdub_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = hdub_pkg::ST_FINISH;
        end
      end
      hdub_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = hdub_pkg::ST_IDLE;
        end
      end
      default: state_d = hdub_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hdub_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HDUB_ASSERT(a_exec_then_finish, clk_i, rst_ni, cmd_o.exec |=> !in_ready_o, "item taken while busy")
  `HDUB_NEVER(a_exec_finish_excl, clk_i, rst_ni, cmd_o.exec && cmd_o.finish, "exec with finish")
  `HDUB_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")

endmodule

[src/hdub_dp.sv]
// Datapath of the half-duplex UART buffer controller: rings, pointers,
// mode flags and the output register. Depends on hdub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hdub_dp #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hdub_pkg::hdub_cmd_t     cmd_i,
  output hdub_pkg::hdub_status_t  status_o,
  input  logic [1:0]             opcode_i,
  input  logic [7:0]             data_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [hdub_pkg::OutWidth-1:0] out_data_o
);

  localparam int unsigned TPW = $clog2(TX_DEPTH);
  localparam int unsigned RPW = $clog2(RX_DEPTH);
  localparam logic [TPW-1:0] TxLast = TPW'(TX_DEPTH - 1);
  localparam logic [RPW-1:0] RxLast = RPW'(RX_DEPTH - 1);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rd_data_q, rx_rd_data_q;

  logic [TPW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d, tx_wr_nx, tx_rd_nx;
  logic [RPW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d, rx_wr_nx, rx_rd_nx;
  logic sending_q, sending_d, second_q, second_d, receiving_q, receiving_d;
  logic overflow_q, overflow_d, pending_q, pending_d;
  logic [7:0] cur_byte_q;

  logic tx_we, tx_re, rx_we, rx_re;
  logic res_wacc_d, res_wacc_q, res_rvalid_d, res_rvalid_q, res_rel_d, res_rel_q;
  hdub_pkg::hdub_load_e res_ld_d, res_ld_q;
  hdub_pkg::hdub_op_e op;

  logic out_valid_q;
  logic [hdub_pkg::OutWidth-1:0] out_data_q;
  logic [7:0] popped_byte, load_value;

  assign op       = hdub_pkg::hdub_op_e'(opcode_i);
  assign tx_wr_nx = (tx_wr_q == TxLast) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nx = (tx_rd_q == TxLast) ? '0 : tx_rd_q + 1'b1;
  assign rx_wr_nx = (rx_wr_q == RxLast) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nx = (rx_rd_q == RxLast) ? '0 : rx_rd_q + 1'b1;

  // State update of one item; only committed when the item is transferred.
  always_comb begin
    tx_wr_d = tx_wr_q;  tx_rd_d = tx_rd_q;
    rx_wr_d = rx_wr_q;  rx_rd_d = rx_rd_q;
    sending_d = sending_q;  second_d = second_q;  receiving_d = receiving_q;
    overflow_d = overflow_q;  pending_d = pending_q;
    tx_we = 1'b0;  tx_re = 1'b0;  rx_we = 1'b0;  rx_re = 1'b0;
    res_wacc_d = 1'b0;  res_rvalid_d = 1'b0;  res_rel_d = 1'b0;
    res_ld_d = hdub_pkg::LD_NONE;
    unique case (op)
      hdub_pkg::OP_WRITE: begin
        if (tx_wr_nx != tx_rd_q) begin
          tx_we      = 1'b1;
          tx_wr_d    = tx_wr_nx;
          res_wacc_d = 1'b1;
          if (!sending_q) begin
            if (receiving_q) begin
              pending_d = 1'b1;
            end else begin
              sending_d = 1'b1;
              pending_d = 1'b0;
              res_ld_d  = hdub_pkg::LD_START;
            end
          end
        end
      end
      hdub_pkg::OP_READ: begin
        if (rx_wr_q != rx_rd_q) begin
          rx_re        = 1'b1;
          rx_rd_d      = rx_rd_nx;
          res_rvalid_d = 1'b1;
        end
      end
      hdub_pkg::OP_START: begin
        if (!sending_q) receiving_d = 1'b1;
      end
      hdub_pkg::OP_SHIFT: begin
        if (sending_q) begin
          if (second_q) begin
            second_d = 1'b0;
            res_ld_d = hdub_pkg::LD_SECOND;
          end else if (tx_wr_q != tx_rd_q) begin
            tx_re    = 1'b1;
            tx_rd_d  = tx_rd_nx;
            second_d = 1'b1;
            res_ld_d = hdub_pkg::LD_FIRST;
          end else begin
            sending_d = 1'b0;
            res_rel_d = 1'b1;
          end
        end else begin
          // End of a reception: store the byte unless the ring is full.
          receiving_d = 1'b0;
          if (rx_wr_nx == rx_rd_q) begin
            overflow_d = 1'b1;
          end else begin
            rx_we   = 1'b1;
            rx_wr_d = rx_wr_nx;
          end
          if (pending_q) begin
            sending_d = 1'b1;
            pending_d = 1'b0;
            res_ld_d  = hdub_pkg::LD_START;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && tx_we) tx_mem[tx_wr_nx] <= hdub_pkg::rev8(data_in_i);
    if (cmd_i.exec && tx_re) tx_rd_data_q <= tx_mem[tx_rd_nx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rx_we) rx_mem[rx_wr_nx] <= data_in_i;
    if (cmd_i.exec && rx_re) rx_rd_data_q <= rx_mem[rx_rd_nx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wr_q <= '0;  tx_rd_q <= '0;  rx_wr_q <= '0;  rx_rd_q <= '0;
      sending_q <= 1'b0;  second_q <= 1'b0;  receiving_q <= 1'b0;
      overflow_q <= 1'b0;  pending_q <= 1'b0;
      res_wacc_q <= 1'b0;  res_rvalid_q <= 1'b0;  res_rel_q <= 1'b0;
      res_ld_q <= hdub_pkg::LD_NONE;
      cur_byte_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        tx_wr_q <= tx_wr_d;  tx_rd_q <= tx_rd_d;
        rx_wr_q <= rx_wr_d;  rx_rd_q <= rx_rd_d;
        sending_q <= sending_d;  second_q <= second_d;  receiving_q <= receiving_d;
        overflow_q <= overflow_d;  pending_q <= pending_d;
        res_wacc_q <= res_wacc_d;  res_rvalid_q <= res_rvalid_d;
        res_rel_q <= res_rel_d;  res_ld_q <= res_ld_d;
      end
      // The byte fetched for a first half is kept for the second half.
      if (cmd_i.finish && res_ld_q == hdub_pkg::LD_FIRST) cur_byte_q <= tx_rd_data_q;
    end
  end

  assign popped_byte = res_rvalid_q ? hdub_pkg::rev8(rx_rd_data_q) : 8'h00;

  always_comb begin
    unique case (res_ld_q)
      hdub_pkg::LD_NONE:   load_value = 8'h00;
      hdub_pkg::LD_START:  load_value = hdub_pkg::StartLoad;
      hdub_pkg::LD_FIRST:  load_value = (tx_rd_data_q >> 2) | hdub_pkg::FirstMark;
      hdub_pkg::LD_SECOND: load_value = (cur_byte_q << 3) | hdub_pkg::SecondMark;
      default:             load_value = 8'h00;
    endcase
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {(rx_wr_q != rx_rd_q), overflow_q, receiving_q, sending_q,
                     res_rel_q, load_value, (res_ld_q != hdub_pkg::LD_NONE),
                     popped_byte, res_rvalid_q, res_wacc_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HDUB_NEVER(a_half_duplex, clk_i, rst_ni, sending_q && receiving_q, "send and receive at once")
  `HDUB_ASSERT(a_pending_rx, clk_i, rst_ni, pending_q |-> receiving_q, "pending without reception")
  `HDUB_ASSERT(a_second_tx, clk_i, rst_ni, second_q |-> sending_q, "second half while not sending")
  `HDUB_ASSERT(a_ovf_sticky, clk_i, rst_ni, overflow_q |=> overflow_q, "overflow flag cleared")

endmodule

[src/half_duplex_uart_buffer_ctrl.sv]
// Top level of the half-duplex UART buffer controller.
// Instantiates hdub_ctrl and hdub_dp; depends on hdub_pkg.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser opcode, tdata data_in
// m_axis    out  m_axis_tvalid_o/tready_i       tdata result fields
//
// For each item, the transfer cycle (IDLE) updates pointers and flags and issues
// the ring read, then the FINISH state moves the registered read data into the
// output register. One item is at work at a time.
// Reset clears pointers and flags at once; ring contents need no clearing.
// A result held in the output register stalls only the FINISH state of the
// following item.
module half_duplex_uart_buffer_ctrl #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] data_in
  input  logic [hdub_pkg::InBytes*8-1:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] write_accepted, [1] read_valid, [9:2] popped_byte, [10] load_valid,
  // [18:11] load_value, [19] line_released, [20] sending_now,
  // [21] receiving_now, [22] rx_overflowed, [23] rx_available
  output logic [hdub_pkg::OutWidth-1:0] m_axis_tdata_o
);

  hdub_pkg::hdub_cmd_t    cmd;
  hdub_pkg::hdub_status_t status;

  hdub_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hdub_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .opcode_i    (s_axis_tuser_i),
    .data_in_i   (s_axis_tdata_i[7:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
